[design/ttmb_pkg.sv]
// ----------------------------------------------------------------------------
// ttmb_pkg: shared types and constants for the minute bar builder
// Holds the controller states, the operation codes of the arithmetic
// sequence, and the command and status groups between the two modules.
// ----------------------------------------------------------------------------
package ttmb_pkg;

    // Time arithmetic constants.
    localparam int unsigned MINUTE_MS = 60000;
    localparam int unsigned TIME_MOD  = 100000;

    // Time mod 100000 uses t / 100000 = (t >> 5) / 3125. For x below 2^23,
    // (x * MOD_RECIP) >> 35 gives x / 3125 exactly.
    localparam logic [23:0] MOD_RECIP = 24'd10995117;

    // Restoring divider: 63 quotient bits, one per cycle.
    localparam int unsigned DIV_STEPS = 63;
    localparam int unsigned DIV_CNT_W = 6;

    // Bar status codes.
    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_SHORT     = 2'd1;
    localparam logic [1:0] STATUS_ZERO_SPAN = 2'd2;

    // Operations of the arithmetic sequence, in order. The two time modulos
    // use the reciprocal multiply; the four terms use the shared divider.
    typedef enum logic [2:0] {
        OP_MOD_PREV,
        OP_MOD_SEC,
        OP_VOL_TAIL,
        OP_VOL_HEAD,
        OP_TURN_TAIL,
        OP_TURN_HEAD
    } op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_START,
        ST_RUN,
        ST_STORE,
        ST_SUM1,
        ST_SUM2,
        ST_FIN
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic tick;
        logic out_short;
        logic load;
        logic div_init;
        logic div_step;
        logic store;
        logic sum1;
        logic sum2;
        logic fin;
        op_t  op;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic count_ge2;
    } stat_t;

endpackage

[design/ttmb_ctrl.sv]
// ----------------------------------------------------------------------------
// ttmb_ctrl: controller for the minute bar builder
// Accepts ticks, sequences the modulo and interpolation divisions for a
// closing tick, and owns the result valid flag.
// ----------------------------------------------------------------------------
module ttmb_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    input  logic             s_tlast,
    input  logic             s_first,
    output logic             s_tready,
    output logic             m_tvalid,
    input  logic             m_tready,
    input  ttmb_pkg::stat_t  stat,
    output ttmb_pkg::cmd_t   cmd
);

    ttmb_pkg::state_t               state_reg, state_next;
    ttmb_pkg::op_t                  op_reg, op_next;
    logic [ttmb_pkg::DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic                           out_valid_reg, out_valid_next;
    logic                           acc;
    logic                           long_bar;

    // A closing item waits until the result register is free.
    assign s_tready = (state_reg == ttmb_pkg::ST_IDLE) && (!out_valid_reg || !s_tlast);
    assign acc      = s_tvalid && s_tready;
    assign long_bar = acc && s_tlast && !s_first && stat.count_ge2;
    assign m_tvalid = out_valid_reg;

    // Next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ttmb_pkg::ST_IDLE: begin
                if (long_bar) state_next = ttmb_pkg::ST_LOAD;
            end
            // The time modulos finish in the store cycle after the load.
            ttmb_pkg::ST_LOAD: begin
                if (op_reg == ttmb_pkg::OP_MOD_PREV || op_reg == ttmb_pkg::OP_MOD_SEC)
                    state_next = ttmb_pkg::ST_STORE;
                else state_next = ttmb_pkg::ST_START;
            end
            ttmb_pkg::ST_START: state_next = ttmb_pkg::ST_RUN;
            ttmb_pkg::ST_RUN: begin
                if (cnt_reg == ttmb_pkg::DIV_CNT_W'(ttmb_pkg::DIV_STEPS - 1))
                    state_next = ttmb_pkg::ST_STORE;
            end
            ttmb_pkg::ST_STORE: begin
                if (op_reg == ttmb_pkg::OP_TURN_HEAD) state_next = ttmb_pkg::ST_SUM1;
                else state_next = ttmb_pkg::ST_LOAD;
            end
            ttmb_pkg::ST_SUM1: state_next = ttmb_pkg::ST_SUM2;
            ttmb_pkg::ST_SUM2: state_next = ttmb_pkg::ST_FIN;
            ttmb_pkg::ST_FIN:  state_next = ttmb_pkg::ST_IDLE;
            default:           state_next = ttmb_pkg::ST_IDLE;
        endcase
    end

    // Commands.
    always_comb begin
        cmd    = '0;
        cmd.op = op_reg;
        case (state_reg)
            ttmb_pkg::ST_IDLE: begin
                cmd.tick      = acc;
                cmd.out_short = acc && s_tlast && (s_first || !stat.count_ge2);
            end
            ttmb_pkg::ST_LOAD:  cmd.load     = 1'b1;
            ttmb_pkg::ST_START: cmd.div_init = 1'b1;
            ttmb_pkg::ST_RUN:   cmd.div_step = 1'b1;
            ttmb_pkg::ST_STORE: cmd.store    = 1'b1;
            ttmb_pkg::ST_SUM1:  cmd.sum1     = 1'b1;
            ttmb_pkg::ST_SUM2:  cmd.sum2     = 1'b1;
            ttmb_pkg::ST_FIN:   cmd.fin      = 1'b1;
            default:            cmd.op       = op_reg;
        endcase
    end

    // Operation index, step counter and result valid.
    always_comb begin
        op_next = op_reg;
        if (long_bar) op_next = ttmb_pkg::OP_MOD_PREV;
        else if (cmd.store && op_reg != ttmb_pkg::OP_TURN_HEAD)
            op_next = ttmb_pkg::op_t'(op_reg + 3'd1);
        cnt_next = cnt_reg;
        if (cmd.div_init) cnt_next = '0;
        else if (cmd.div_step) cnt_next = cnt_reg + 1'b1;
        out_valid_next = out_valid_reg;
        if (cmd.out_short || cmd.fin) out_valid_next = 1'b1;
        else if (m_tready) out_valid_next = 1'b0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ttmb_pkg::ST_IDLE;
            op_reg        <= ttmb_pkg::OP_MOD_PREV;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            op_reg        <= op_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

[design/ttmb_dpath.sv]
// ----------------------------------------------------------------------------
// ttmb_dpath: datapath for the minute bar builder
// Window registers, operand setup with one multiplier, a reciprocal multiply
// for the time modulos, a shared restoring divider, saturating sums and the
// result register.
// ----------------------------------------------------------------------------
module ttmb_dpath (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  ttmb_pkg::cmd_t       cmd,
    output ttmb_pkg::stat_t      stat,
    input  logic [31:0]          tick_price,
    input  logic [39:0]          cum_volume,
    input  logic [45:0]          cum_turnover,
    input  logic [27:0]          tick_time,
    input  logic [26:0]          tick_date,
    input  logic                 window_first,
    input  logic                 window_last,
    output logic [26:0]          bar_date,
    output logic [27:0]          bar_time,
    output logic [31:0]          prior_close,
    output logic [31:0]          open_price,
    output logic [31:0]          close_price,
    output logic [31:0]          high_price,
    output logic [31:0]          low_price,
    output logic signed [47:0]   bar_volume,
    output logic signed [53:0]   bar_turnover,
    output logic [1:0]           bar_status
);

    // Window state.
    logic [1:0]  count_reg;
    logic [39:0] start_vol_reg, sec_vol_reg, prev_vol_reg, cur_vol_reg;
    logic [45:0] start_turn_reg, sec_turn_reg, prev_turn_reg, cur_turn_reg;
    logic [27:0] start_time_reg, sec_time_reg, prev_time_reg, cur_time_reg;
    logic [26:0] cur_date_reg;
    logic [31:0] start_price_reg, open_reg, prev_price_reg, high_reg, low_reg;

    // Arithmetic state.
    logic [16:0]        pmod_reg, smod_reg;
    logic [62:0]        opnd_reg, q_reg;
    logic [27:0]        dsr_reg, rem_reg;
    logic               neg_reg, zspan_reg, zero_flag_reg;
    logic signed [63:0] vt_reg, vh_reg, tt_reg, th_reg;
    logic signed [63:0] accv_reg, acct_reg, sumv_reg, sumt_reg;

    // Operand setup.
    logic signed [47:0] dv;
    logic signed [17:0] mul;
    logic signed [28:0] span;
    logic [46:0]        dv_mag;
    logic [16:0]        mul_mag;
    logic [27:0]        span_mag;
    logic [63:0]        prod;
    logic [62:0]        ld_opnd;
    logic [27:0]        ld_dsr;
    logic               is_mod;

    // Time modulo by reciprocal multiplication.
    logic [11:0]        qmod_reg;
    logic [27:0]        mod_src;
    logic [46:0]        recip_prod;
    logic [28:0]        qmod_scaled;
    logic [16:0]        mod_rem;

    // Divider step.
    logic [28:0]        rem_sh;
    logic               ge;
    logic signed [63:0] term_q, term_val;
    logic               is_tail;
    logic               start_nz;

    function automatic logic signed [63:0] sat_add(input logic signed [63:0] a,
                                                  input logic signed [63:0] b);
        logic signed [64:0] s;
        s = {a[63], a} + {b[63], b};
        if (s[64] != s[63]) sat_add = s[64] ? {1'b1, 63'b0} : {1'b0, {63{1'b1}}};
        else sat_add = s[63:0];
    endfunction

    assign stat.count_ge2 = count_reg[1];

    // Select operands for the current operation.
    always_comb begin
        dv     = '0;
        mul    = '0;
        span   = '0;
        is_mod = 1'b0;
        case (cmd.op)
            ttmb_pkg::OP_MOD_PREV, ttmb_pkg::OP_MOD_SEC: is_mod = 1'b1;
            ttmb_pkg::OP_VOL_TAIL: begin
                dv   = {8'b0, cur_vol_reg} - {8'b0, prev_vol_reg};
                mul  = 18'(ttmb_pkg::MINUTE_MS) - {1'b0, pmod_reg};
                span = {1'b0, cur_time_reg} - {1'b0, prev_time_reg};
            end
            ttmb_pkg::OP_VOL_HEAD: begin
                dv   = {8'b0, sec_vol_reg} - {8'b0, start_vol_reg};
                mul  = {1'b0, smod_reg};
                span = {1'b0, sec_time_reg} - {1'b0, start_time_reg};
            end
            ttmb_pkg::OP_TURN_TAIL: begin
                dv   = {2'b0, cur_turn_reg} - {2'b0, prev_turn_reg};
                mul  = 18'(ttmb_pkg::MINUTE_MS) - {1'b0, pmod_reg};
                span = {1'b0, cur_time_reg} - {1'b0, prev_time_reg};
            end
            ttmb_pkg::OP_TURN_HEAD: begin
                dv   = {2'b0, sec_turn_reg} - {2'b0, start_turn_reg};
                mul  = {1'b0, smod_reg};
                span = {1'b0, sec_time_reg} - {1'b0, start_time_reg};
            end
            default: is_mod = 1'b0;
        endcase
        dv_mag   = dv[47] ? 47'(-dv) : dv[46:0];
        mul_mag  = mul[17] ? 17'(-mul) : mul[16:0];
        span_mag = span[28] ? 28'(-span) : span[27:0];
        prod     = {17'b0, dv_mag} * {47'b0, mul_mag};
        ld_opnd  = prod[62:0];
        ld_dsr   = span_mag;
    end

    // Quotient by 100000 in the load cycle, remainder in the store cycle.
    assign mod_src     = (cmd.op == ttmb_pkg::OP_MOD_PREV) ? prev_time_reg : sec_time_reg;
    assign recip_prod  = {24'b0, mod_src[27:5]} * {23'b0, ttmb_pkg::MOD_RECIP};
    assign qmod_scaled = {17'b0, qmod_reg} * 29'(ttmb_pkg::TIME_MOD);
    assign mod_rem     = 17'({1'b0, mod_src} - qmod_scaled);

    // One restoring division step and the signed term.
    assign rem_sh   = {rem_reg, q_reg[62]};
    assign ge       = rem_sh >= {1'b0, dsr_reg};
    assign term_q   = {1'b0, q_reg};
    assign term_val = zspan_reg ? 64'sd0 : (neg_reg ? -term_q : term_q);
    assign is_tail  = (cmd.op == ttmb_pkg::OP_VOL_TAIL) || (cmd.op == ttmb_pkg::OP_TURN_TAIL);
    assign start_nz = (cmd.op == ttmb_pkg::OP_VOL_HEAD) ? (start_vol_reg != '0)
                                                         : (start_turn_reg != '0);

    // Tick counter.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= 2'd0;
        end else if (cmd.tick) begin
            if (window_first) count_reg <= window_last ? 2'd0 : 2'd1;
            else if (window_last) count_reg <= 2'd0;
            else if (count_reg == 2'd1) count_reg <= 2'd2;
            else if (count_reg != 2'd0) count_reg <= 2'd3;
        end
    end

    // Window payload.
    always_ff @(posedge aclk) begin
        if (cmd.tick) begin
            if (window_first) begin
                start_price_reg <= tick_price;
                start_vol_reg   <= cum_volume;
                start_turn_reg  <= cum_turnover;
                start_time_reg  <= tick_time;
            end else if (window_last) begin
                cur_vol_reg  <= cum_volume;
                cur_turn_reg <= cum_turnover;
                cur_time_reg <= tick_time;
                cur_date_reg <= tick_date;
            end else if (count_reg != 2'd0) begin
                if (count_reg == 2'd1) begin
                    sec_vol_reg  <= cum_volume;
                    sec_turn_reg <= cum_turnover;
                    sec_time_reg <= tick_time;
                    open_reg     <= tick_price;
                    high_reg     <= tick_price;
                    low_reg      <= tick_price;
                end else begin
                    if (tick_price > high_reg) high_reg <= tick_price;
                    if (tick_price < low_reg) low_reg <= tick_price;
                end
                prev_price_reg <= tick_price;
                prev_vol_reg   <= cum_volume;
                prev_turn_reg  <= cum_turnover;
                prev_time_reg  <= tick_time;
            end
        end
    end

    // Operand register, divider and term storage.
    always_ff @(posedge aclk) begin
        if (cmd.tick) zero_flag_reg <= 1'b0;
        if (cmd.load) begin
            opnd_reg  <= ld_opnd;
            dsr_reg   <= ld_dsr;
            neg_reg   <= !is_mod && (dv[47] ^ mul[17] ^ span[28]);
            zspan_reg <= !is_mod && (span == '0);
            if (is_mod) qmod_reg <= recip_prod[46:35];
        end
        if (cmd.div_init) begin
            q_reg   <= opnd_reg;
            rem_reg <= '0;
        end else if (cmd.div_step) begin
            q_reg   <= {q_reg[61:0], ge};
            rem_reg <= ge ? 28'(rem_sh - {1'b0, dsr_reg}) : rem_sh[27:0];
        end
        if (cmd.store) begin
            if (zspan_reg && (is_tail || start_nz)) zero_flag_reg <= 1'b1;
            case (cmd.op)
                ttmb_pkg::OP_MOD_PREV:  pmod_reg <= mod_rem;
                ttmb_pkg::OP_MOD_SEC:   smod_reg <= mod_rem;
                ttmb_pkg::OP_VOL_TAIL:  vt_reg   <= term_val;
                ttmb_pkg::OP_VOL_HEAD:  vh_reg   <= term_val;
                ttmb_pkg::OP_TURN_TAIL: tt_reg   <= term_val;
                ttmb_pkg::OP_TURN_HEAD: th_reg   <= term_val;
                default:                pmod_reg <= pmod_reg;
            endcase
        end
        // Head term plus the inner-minute difference.
        if (cmd.sum1) begin
            accv_reg <= sat_add(vh_reg, 64'({24'b0, prev_vol_reg}) - 64'({24'b0, sec_vol_reg}));
            acct_reg <= sat_add(th_reg,
                                64'({18'b0, prev_turn_reg}) - 64'({18'b0, sec_turn_reg}));
        end
        // Tail term; a zero start value uses the inner value directly.
        if (cmd.sum2) begin
            sumv_reg <= (start_vol_reg == '0) ? sat_add(64'({24'b0, prev_vol_reg}), vt_reg)
                                              : sat_add(accv_reg, vt_reg);
            sumt_reg <= (start_turn_reg == '0) ? sat_add(64'({18'b0, prev_turn_reg}), tt_reg)
                                               : sat_add(acct_reg, tt_reg);
        end
    end

    // Result register.
    always_ff @(posedge aclk) begin
        if (cmd.out_short) begin
            bar_date     <= tick_date;
            bar_time     <= '0;
            prior_close  <= '0;
            open_price   <= '0;
            close_price  <= '0;
            high_price   <= '0;
            low_price    <= '0;
            bar_volume   <= '0;
            bar_turnover <= '0;
            bar_status   <= ttmb_pkg::STATUS_SHORT;
        end else if (cmd.fin) begin
            bar_date    <= cur_date_reg;
            bar_time    <= prev_time_reg;
            prior_close <= start_price_reg;
            open_price  <= open_reg;
            close_price <= prev_price_reg;
            high_price  <= high_reg;
            low_price   <= low_reg;
            if (sumv_reg[63:47] == {17{sumv_reg[63]}}) bar_volume <= sumv_reg[47:0];
            else bar_volume <= sumv_reg[63] ? {1'b1, 47'b0} : {1'b0, {47{1'b1}}};
            if (sumt_reg[63:53] == {11{sumt_reg[63]}}) bar_turnover <= sumt_reg[53:0];
            else bar_turnover <= sumt_reg[63] ? {1'b1, 53'b0} : {1'b0, {53{1'b1}}};
            bar_status <= zero_flag_reg ? ttmb_pkg::STATUS_ZERO_SPAN : ttmb_pkg::STATUS_OK;
        end
    end

endmodule

[design/tick_to_minute_bar.sv]
// A closing tick of a full window starts two time modulos by reciprocal multiply,
// then four interpolation terms through the 63-step restoring divider, then the
// head and tail sums and the result write.
// A short window gives its status-1 item in the cycle after the closing tick.
// Throughput: one tick per cycle, but input is held off while a bar is computed.
// Reset (aresetn low, synchronous) closes any open window and drops the result.
// ----------------------------------------------------------------------------
// tick_to_minute_bar: minute OHLC bar builder with interpolated volume
// Joins the controller and the datapath and packs the stream ports.
// ----------------------------------------------------------------------------
module tick_to_minute_bar (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // tick_price, cum_volume, cum_turnover, tick_time, tick_date
    input  logic [175:0] s_tdata,
    // window_first
    input  logic [0:0]   s_tuser,
    input  logic         s_tlast,
    output logic         m_tvalid,
    input  logic         m_tready,
    // bar_date, bar_time, prior_close, open_price, close_price, high_price,
    // low_price, bar_volume, bar_turnover
    output logic [319:0] m_tdata,
    // bar_status
    output logic [1:0]   m_tuser
);

    ttmb_pkg::cmd_t     cmd;
    ttmb_pkg::stat_t    stat;
    logic [26:0]        bar_date;
    logic [27:0]        bar_time;
    logic [31:0]        prior_close, open_price, close_price, high_price, low_price;
    logic signed [47:0] bar_volume;
    logic signed [53:0] bar_turnover;

    ttmb_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tlast  (s_tlast),
        .s_first  (s_tuser[0]),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    ttmb_dpath u_dpath (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .stat         (stat),
        .tick_price   (s_tdata[31:0]),
        .cum_volume   (s_tdata[71:32]),
        .cum_turnover (s_tdata[117:72]),
        .tick_time    (s_tdata[145:118]),
        .tick_date    (s_tdata[172:146]),
        .window_first (s_tuser[0]),
        .window_last  (s_tlast),
        .bar_date     (bar_date),
        .bar_time     (bar_time),
        .prior_close  (prior_close),
        .open_price   (open_price),
        .close_price  (close_price),
        .high_price   (high_price),
        .low_price    (low_price),
        .bar_volume   (bar_volume),
        .bar_turnover (bar_turnover),
        .bar_status   (m_tuser)
    );

    assign m_tdata = {3'b0, bar_turnover, bar_volume, low_price, high_price, close_price,
                      open_price, prior_close, bar_time, bar_date};

    // A new result is only written into a free result register.
    a_out_free: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.out_short || cmd.fin) |-> !m_tvalid)
        else $error("result register overwritten");

    // No item is taken while the arithmetic sequence runs.
    a_busy_no_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.load || cmd.div_step || cmd.store || cmd.sum1 || cmd.sum2) |-> !s_tready)
        else $error("item accepted during bar computation");

    // At most one datapath action per cycle, out_short apart, which comes with a tick.
    a_cmd_onehot: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0({cmd.tick, cmd.load, cmd.div_init, cmd.div_step, cmd.store,
                  cmd.sum1, cmd.sum2, cmd.fin}))
        else $error("conflicting datapath commands");

    // The final sum is always followed by a valid result.
    a_fin_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.fin |=> m_tvalid)
        else $error("bar lost after final sum");

endmodule

[verif/tb_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the minute bar builder
// Sends windows of ticks over the input stream and predicts each bar with a
// behavioral model of the OHLC and interpolation rules. Every bar that comes
// out is compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module tb_top;

    typedef struct {
        logic [31:0] price;
        logic [39:0] vol;
        logic [45:0] turn;
        logic [27:0] tm;
        logic [26:0] dt;
        logic        first;
        logic        last;
    } tick_t;

    typedef struct {
        logic [26:0] dt;
        logic [27:0] tm;
        logic [31:0] prior;
        logic [31:0] open_p;
        logic [31:0] close_p;
        logic [31:0] high_p;
        logic [31:0] low_p;
        logic [47:0] vol;
        logic [53:0] turn;
        logic [1:0]  status;
    } bar_t;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam longint MAX_TIME = 235959999;
    localparam longint MAX_DATE = 99991231;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [175:0] s_tdata = '0;
    logic [0:0]   s_tuser = '0;
    logic         s_tlast = 1'b0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [319:0] m_tdata;
    logic [1:0]   m_tuser;

    bar_t   expected_bars[$];
    int     fail_count = 0;
    bit     idle_on = 1'b1;
    int     stall_left = 0;
    int     quiet_cycles = 0;

    // Predictor state, mirrors the window registers of the block.
    logic [39:0] w_start_vol, w_sec_vol, w_prev_vol;
    logic [45:0] w_start_turn, w_sec_turn, w_prev_turn;
    logic [27:0] w_start_time, w_sec_time, w_prev_time;
    logic [31:0] w_start_price, w_open, w_prev_price, w_high, w_low;
    int          w_count = 0;
    bit          span_zero;

    tick_to_minute_bar u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .s_tuser(s_tuser), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tuser(m_tuser)
    );

    always #5 aclk = ~aclk;

    // Scaled edge term; an empty time span contributes nothing and flags status.
    function automatic longint edge_term(longint dv, longint mul, longint span);
        if (span == 0) begin
            span_zero = 1'b1;
            return 0;
        end
        return (dv * mul) / span;
    endfunction

    function automatic longint add_sat(longint a, longint b);
        longint max_v;
        longint min_v;
        max_v = 64'h7fff_ffff_ffff_ffff;
        min_v = 64'h8000_0000_0000_0000;
        if (b > 0 && a > max_v - b) return max_v;
        if (b < 0 && a < min_v - b) return min_v;
        return a + b;
    endfunction

    function automatic longint clamp_width(longint v, int w);
        longint hi;
        hi = (longint'(1) <<< (w - 1)) - 1;
        if (v > hi) return hi;
        if (v < -hi - 1) return -hi - 1;
        return v;
    endfunction

    // Interpolates a cumulative quantity across both minute edges.
    function automatic longint interp_cum(longint s, longint sec, longint pv,
                                          longint cur, longint cur_time);
        longint tail;
        longint acc;
        longint tmod;
        tmod = longint'(ttmb_pkg::TIME_MOD);
        tail = edge_term(cur - pv,
                         longint'(ttmb_pkg::MINUTE_MS) - longint'(w_prev_time) % tmod,
                         cur_time - longint'(w_prev_time));
        if (s == 0) return add_sat(pv, tail);
        acc = edge_term(sec - s, longint'(w_sec_time) % tmod,
                        longint'(w_sec_time) - longint'(w_start_time));
        acc = add_sat(acc, pv - sec);
        return add_sat(acc, tail);
    endfunction

    // Advances the window state by one tick and queues the bar it closes.
    function automatic void predict_bar(tick_t t);
        bar_t   b;
        longint v;
        longint tr;
        b = '{default: '0};
        b.dt = t.dt;
        if (t.first) begin
            w_start_price = t.price;
            w_start_vol = t.vol;
            w_start_turn = t.turn;
            w_start_time = t.tm;
            w_count = 1;
            if (!t.last) return;
            w_count = 0;
            b.status = ttmb_pkg::STATUS_SHORT;
            expected_bars.push_back(b);
            return;
        end
        if (!t.last) begin
            if (w_count == 0) return;
            if (w_count == 1) begin
                w_sec_vol = t.vol;
                w_sec_turn = t.turn;
                w_sec_time = t.tm;
                w_open = t.price;
                w_high = t.price;
                w_low = t.price;
                w_count = 2;
            end else begin
                if (t.price > w_high) w_high = t.price;
                if (t.price < w_low) w_low = t.price;
                w_count = 3;
            end
            w_prev_price = t.price;
            w_prev_vol = t.vol;
            w_prev_turn = t.turn;
            w_prev_time = t.tm;
            return;
        end
        if (w_count < 2) begin
            w_count = 0;
            b.status = ttmb_pkg::STATUS_SHORT;
            expected_bars.push_back(b);
            return;
        end
        w_count = 0;
        span_zero = 1'b0;
        v = interp_cum(w_start_vol, w_sec_vol, w_prev_vol, t.vol, t.tm);
        tr = interp_cum(w_start_turn, w_sec_turn, w_prev_turn, t.turn, t.tm);
        b.tm = w_prev_time;
        b.prior = w_start_price;
        b.open_p = w_open;
        b.close_p = w_prev_price;
        b.high_p = w_high;
        b.low_p = w_low;
        b.vol = 48'(clamp_width(v, 48));
        b.turn = 54'(clamp_width(tr, 54));
        b.status = span_zero ? ttmb_pkg::STATUS_ZERO_SPAN : ttmb_pkg::STATUS_OK;
        expected_bars.push_back(b);
    endfunction

    // Sends one tick, with a random idle burst ahead of it while idling is on.
    task automatic send_tick(tick_t t);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {3'b0, t.dt, t.tm, t.turn, t.vol, t.price};
        s_tuser <= t.first;
        s_tlast <= t.last;
        do @(posedge aclk); while (!s_tready);
        predict_bar(t);
    endtask

    function automatic tick_t make_tick(logic first, logic last, longint tm);
        tick_t t;
        t.price = $urandom;
        t.vol = 40'({$urandom, $urandom});
        t.turn = 46'({$urandom, $urandom});
        t.tm = 28'(tm);
        t.dt = 27'($urandom_range(0, MAX_DATE));
        t.first = first;
        t.last = last;
        return t;
    endfunction

    // One well-formed window: opening tick, inner ticks, closing tick.
    task automatic send_window(int inner, bit start_zero, bit flat_time);
        tick_t  t;
        longint tm;
        longint vol;
        longint turn;
        tm = $urandom_range(0, MAX_TIME - 200000);
        vol = start_zero ? 0 : $urandom_range(0, 1000000);
        turn = start_zero ? 0 : longint'($urandom) * 8;
        t = make_tick(1'b1, 1'b0, tm);
        t.vol = 40'(vol);
        t.turn = 46'(turn);
        send_tick(t);
        for (int i = 0; i <= inner; i++) begin
            if (!flat_time) tm += $urandom_range(0, 20000);
            vol += $urandom_range(0, 5000);
            turn += $urandom_range(0, 500000);
            t = make_tick(1'b0, i == inner, tm);
            if ($urandom_range(0, 9) != 0) begin
                t.vol = 40'(vol);
                t.turn = 46'(turn);
            end
            send_tick(t);
        end
    endtask

    task automatic test_short_windows();
        tick_t t;
        // Closing tick with no window open, then both flags on one tick.
        send_tick(make_tick(1'b0, 1'b1, 1000));
        send_tick(make_tick(1'b1, 1'b1, 2000));
        // Stray tick that is dropped, then a window with only one tick.
        send_tick(make_tick(1'b0, 1'b0, 3000));
        send_tick(make_tick(1'b1, 1'b0, 4000));
        send_tick(make_tick(1'b0, 1'b1, 5000));
        // Reopening a window restarts it.
        send_tick(make_tick(1'b1, 1'b0, 6000));
        send_tick(make_tick(1'b1, 1'b0, 7000));
        t = make_tick(1'b0, 1'b1, 8000);
        send_tick(t);
    endtask

    task automatic test_edge_values();
        tick_t t;
        t = make_tick(1'b1, 1'b0, 0);
        t.price = '1; t.vol = '1; t.turn = '1; t.dt = 27'(MAX_DATE);
        send_tick(t);
        t = make_tick(1'b0, 1'b0, MAX_TIME - 1);
        t.price = '0; t.vol = '0; t.turn = '0;
        send_tick(t);
        t = make_tick(1'b0, 1'b0, 99999);
        t.price = '1; t.vol = '1; t.turn = '1;
        send_tick(t);
        t = make_tick(1'b0, 1'b1, MAX_TIME);
        t.vol = '0; t.turn = '0; t.dt = '0;
        send_tick(t);
        // Start volume of zero takes only the tail term.
        send_window(2, 1'b1, 1'b0);
    endtask

    task automatic test_zero_span();
        send_window(1, 1'b0, 1'b1);
        send_window(3, 1'b0, 1'b1);
        // Hold the input until every bar is out.
        s_tvalid <= 1'b0;
        wait (expected_bars.size() == 0);
        @(posedge aclk);
    endtask

    task automatic test_random_windows(int n_items);
        int sent;
        int kind;
        int inner;
        sent = 0;
        while (sent < n_items) begin
            kind = $urandom_range(0, 19);
            if (kind < 16) begin
                inner = $urandom_range(0, 7);
                send_window(inner, kind == 0, kind == 1);
                sent += inner + 2;
            end else begin
                send_tick(make_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                                    $urandom_range(0, MAX_TIME)));
                sent += 1;
            end
        end
    endtask

    // Output side: accepted bars are checked against the oldest prediction.
    always @(posedge aclk) begin
        bar_t e;
        bar_t a;
        if (aresetn && m_tvalid && m_tready) begin
            a.dt = m_tdata[26:0];
            a.tm = m_tdata[54:27];
            a.prior = m_tdata[86:55];
            a.open_p = m_tdata[118:87];
            a.close_p = m_tdata[150:119];
            a.high_p = m_tdata[182:151];
            a.low_p = m_tdata[214:183];
            a.vol = m_tdata[262:215];
            a.turn = m_tdata[316:263];
            a.status = m_tuser;
            if (expected_bars.size() == 0) begin
                $error("unexpected bar item");
                fail_count++;
            end else begin
                e = expected_bars.pop_front();
                if (a.dt !== e.dt) begin
                    $error("bar_date exp %0d got %0d", e.dt, a.dt); fail_count++;
                end
                if (a.tm !== e.tm) begin
                    $error("bar_time exp %0d got %0d", e.tm, a.tm); fail_count++;
                end
                if (a.prior !== e.prior) begin
                    $error("prior_close exp %0d got %0d", e.prior, a.prior); fail_count++;
                end
                if (a.open_p !== e.open_p) begin
                    $error("open_price exp %0d got %0d", e.open_p, a.open_p); fail_count++;
                end
                if (a.close_p !== e.close_p) begin
                    $error("close_price exp %0d got %0d", e.close_p, a.close_p); fail_count++;
                end
                if (a.high_p !== e.high_p) begin
                    $error("high_price exp %0d got %0d", e.high_p, a.high_p); fail_count++;
                end
                if (a.low_p !== e.low_p) begin
                    $error("low_price exp %0d got %0d", e.low_p, a.low_p); fail_count++;
                end
                if (a.vol !== e.vol) begin
                    $error("bar_volume exp %0d got %0d", $signed(e.vol), $signed(a.vol));
                    fail_count++;
                end
                if (a.turn !== e.turn) begin
                    $error("bar_turnover exp %0d got %0d", $signed(e.turn),
                           $signed(a.turn));
                    fail_count++;
                end
                if (a.status !== e.status) begin
                    $error("bar_status exp %0d got %0d", e.status, a.status); fail_count++;
                end
            end
        end
    end

    // Receiver stalls in random bursts while idling is on.
    always @(posedge aclk) begin
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_tready <= 1'b0;
        end else if (idle_on && $urandom_range(0, 5) == 0) begin
            stall_left <= $urandom_range(0, 9);
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // Watchdog on cycles where neither side moves an item.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("tb: failure");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_short_windows();
        test_edge_values();
        test_zero_span();
        test_random_windows(1500);
        idle_on = 1'b0;
        test_random_windows(300);
        s_tvalid <= 1'b0;
        wait (expected_bars.size() == 0);
        repeat (450) @(posedge aclk);
        if (fail_count == 0 && expected_bars.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end
endmodule

[sim.f]
design/ttmb_pkg.sv
design/ttmb_ctrl.sv
design/ttmb_dpath.sv
design/tick_to_minute_bar.sv
verif/tb_top.sv
